// ===== rtl/core/wfspt_pkg.sv =====
// ----------------------------------------------------------------------------
// wfspt_pkg
// Shared types and constants of the windowed fan-speed power throttle.
// ----------------------------------------------------------------------------
package wfspt_pkg;

    // Field widths of the transfer payloads and registers.
    localparam int FAN_W    = 7;
    localparam int TEMP_W   = 7;
    localparam int RPS_W    = 5;
    localparam int BUMP_W   = 21;

    // Window bookkeeping.
    localparam int WINDOW_MAX = 64;
    localparam int WLEN_W     = 7;
    localparam int POS_W      = 6;
    localparam int SUM_W      = 13;
    localparam int DIV_W      = 6;

    // Dividend of the window average: 192 times the earlier sum.
    localparam int DVD_W = 21;

    // Width of the shared adder and of the working registers.
    localparam int ALU_W = 28;

    // Configuration port.
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_MAX_FAN  = 2'd0;
    localparam logic [1:0] REG_MAX_TEMP = 2'd1;
    localparam logic [1:0] REG_RPS      = 2'd2;

    localparam logic [FAN_W-1:0]  MAX_FAN_RST  = 7'd80;
    localparam logic [TEMP_W-1:0] MAX_TEMP_RST = 7'd85;
    localparam logic [RPS_W-1:0]  RPS_RST      = 5'd1;

    localparam logic [BUMP_W-1:0] BUMP_UNITY = 21'd256;
    localparam logic [BUMP_W-1:0] BUMP_SAT   = 21'h1F_FFFF;

    typedef enum logic [1:0] {
        ACT_HOLD = 2'd0,
        ACT_INC  = 2'd1,
        ACT_DEC  = 2'd2
    } t_power_action;

    typedef struct packed {
        logic [FAN_W-1:0]  fan_pct;
        logic [TEMP_W-1:0] gpu_temperature;
    } t_in_data;

    typedef struct packed {
        t_power_action     power_action;
        logic              bump_valid;
        logic [BUMP_W-1:0] bump_q8;
    } t_out_data;

endpackage

// ===== rtl/core/windowed_fan_speed_power_throttle_top.sv =====
// ----------------------------------------------------------------------------
// windowed_fan_speed_power_throttle_top
// Groups fan-speed reports into windows and, at the end of each window,
// chooses a power action and a Q8 bump factor with one shared adder.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake                   | Payload
//  ---------+-----------+-----------------------------+-------------------------
//  in       | input     | i_in_valid / o_in_stall     | i_in_data  (t_in_data)
//  out      | output    | o_out_valid / i_out_stall   | o_out_data (t_out_data)
//  config   | input     | psel, penable, pwrite/pready| paddr, pwdata, prdata
//
// A report inside a window is taken and its hold result is in the output
// register in the cycle after. A report that closes a window goes through
// these steps: it is taken, the sum is scaled, the restoring divider runs 21
// steps, three steps form the average and the decision, and the result is
// delivered; when the bump follows from the average, seven shift-and-add steps
// of the multiply by the window length come before delivery, and a negative
// average is first negated in a step of its own. All of these steps share one
// adder.
// Reset is synchronous and active low; it clears the sequencer, the window
// state and the output valid, and returns the registers to their defaults.
// The block takes no report while it works on a window end, nor while the
// output register holds a result that the far side is stalling.
//
module windowed_fan_speed_power_throttle_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  wfspt_pkg::t_in_data                i_in_data,

    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output wfspt_pkg::t_out_data               o_out_data,

    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [wfspt_pkg::PADDR_W-1:0]      paddr,
    input  logic [wfspt_pkg::PDATA_W-1:0]      pwdata,
    output logic [wfspt_pkg::PDATA_W-1:0]      prdata,
    output logic                               pready
);
    import wfspt_pkg::*;

    // One-hot sequencer states.
    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SCALE = 9'b000000010,
        S_DIV   = 9'b000000100,
        S_ACC   = 9'b000001000,
        S_AVG   = 9'b000010000,
        S_SEL   = 9'b000100000,
        S_NEG   = 9'b001000000,
        S_MUL   = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    // ------------------------------------------------------------------
    // Configuration registers and the APB-style port.
    // ------------------------------------------------------------------
    logic [FAN_W-1:0]  r_max_fan;
    logic [TEMP_W-1:0] r_max_temp;
    logic [RPS_W-1:0]  r_rps;
    logic              cfg_write;
    logic [1:0]        cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_fan  <= MAX_FAN_RST;
            r_max_temp <= MAX_TEMP_RST;
            r_rps      <= RPS_RST;
        end else if (cfg_write) begin
            // A write to an address past the last register is dropped.
            if (cfg_index == REG_MAX_FAN) begin
                r_max_fan <= pwdata[FAN_W-1:0];
            end
            if (cfg_index == REG_MAX_TEMP) begin
                r_max_temp <= pwdata[TEMP_W-1:0];
            end
            if (cfg_index == REG_RPS) begin
                r_rps <= pwdata[RPS_W-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (cfg_index == REG_MAX_FAN) begin
            prdata = PDATA_W'(r_max_fan);
        end else if (cfg_index == REG_MAX_TEMP) begin
            prdata = PDATA_W'(r_max_temp);
        end else if (cfg_index == REG_RPS) begin
            prdata = PDATA_W'(r_rps);
        end
    end

    // ------------------------------------------------------------------
    // Window length. A rate of zero counts as one, and the length is
    // clamped to the largest window the position counter can follow.
    // ------------------------------------------------------------------
    logic [RPS_W-1:0]  rps_eff;
    logic [WLEN_W-1:0] wlen;
    logic [DIV_W-1:0]  divisor;

    assign rps_eff = (r_rps == '0) ? RPS_W'(1) : r_rps;
    assign wlen    = (rps_eff >= RPS_W'(WINDOW_MAX / 4)) ? WLEN_W'(WINDOW_MAX)
                                                        : {rps_eff[3:0], 2'b00};
    assign divisor = DIV_W'(wlen - WLEN_W'(1));

    // ------------------------------------------------------------------
    // Sequencer and working registers.
    // ------------------------------------------------------------------
    t_state                   r_state;
    logic [POS_W-1:0]         r_pos;
    logic [SUM_W-1:0]         r_sum;
    logic [FAN_W-1:0]         r_fan;
    logic                     r_hot;
    logic [DVD_W-1:0]         r_quo;
    logic [DIV_W-1:0]         r_rem;
    logic [4:0]               r_cnt;
    logic signed [ALU_W-1:0]  r_acc;
    logic [ALU_W-1:0]         r_prod;
    t_power_action            r_act;
    logic                     r_out_valid;
    t_out_data                r_out_data;

    logic                     out_free;
    logic                     in_accept;
    logic                     window_end;
    logic                     out_load;
    logic [WLEN_W-1:0]        pos_next;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && out_free);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign pos_next   = WLEN_W'(r_pos) + WLEN_W'(1);
    assign window_end = !(pos_next < wlen);

    // A new result enters the output register for an inner report at once,
    // and for a window end once the sequencer has finished.
    assign out_load   = (in_accept && !window_end) || ((r_state == S_DONE) && out_free);

    // ------------------------------------------------------------------
    // The shared adder. Every step that adds to or subtracts from the fan data
    // goes through it; the sequencer state picks the operands and whether to subtract.
    // ------------------------------------------------------------------
    logic signed [ALU_W-1:0] alu_a;
    logic signed [ALU_W-1:0] alu_b;
    logic                    alu_sub;
    logic signed [ALU_W-1:0] alu_res;

    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // Running sum of the fan speeds of the window.
                alu_a = ALU_W'(r_sum);
                alu_b = ALU_W'(i_in_data.fan_pct);
            end
            S_SCALE: begin
                // 192 * sum as 128 * sum + 64 * sum.
                alu_a = ALU_W'({r_sum, 7'b0});
                alu_b = ALU_W'({r_sum, 6'b0});
            end
            S_DIV: begin
                // Trial subtraction of one restoring-division step.
                alu_a   = ALU_W'({r_rem, r_quo[DVD_W-1]});
                alu_b   = ALU_W'(divisor);
                alu_sub = 1'b1;
            end
            S_ACC: begin
                alu_a = ALU_W'(r_quo);
                alu_b = ALU_W'({r_fan, 6'b0});
            end
            S_AVG: begin
                alu_a   = ALU_W'({r_max_fan, 8'b0});
                alu_b   = r_acc;
                alu_sub = 1'b1;
            end
            S_NEG: begin
                alu_b   = r_acc;
                alu_sub = 1'b1;
            end
            S_MUL: begin
                // Partial product of the magnitude and one bit of the length.
                alu_a = ALU_W'(r_prod);
                alu_b = r_acc <<< r_cnt[2:0];
            end
            S_SEL, S_DONE: begin
                alu_a = '0;
            end
            default: begin
                alu_a = '0;
            end
        endcase
        alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_sub);
    end

    // Final bump: halve on an increase, then saturate to the field width.
    logic [ALU_W-1:0]  bump_raw;
    logic [BUMP_W-1:0] bump_final;

    assign bump_raw   = (r_act == ACT_INC) ? (r_prod >> 1) : r_prod;
    assign bump_final = (|bump_raw[ALU_W-1:BUMP_W]) ? BUMP_SAT : bump_raw[BUMP_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // The output register empties when its transfer completes and is
            // refilled whenever a new result is ready.
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        if (window_end) begin
                            r_pos   <= '0;
                            r_fan   <= i_in_data.fan_pct;
                            r_hot   <= (i_in_data.gpu_temperature >= r_max_temp);
                            r_state <= S_SCALE;
                        end else begin
                            r_pos       <= r_pos + POS_W'(1);
                            r_sum       <= alu_res[SUM_W-1:0];
                            r_out_data  <= '{power_action: ACT_HOLD,
                                             bump_valid:   1'b0,
                                             bump_q8:      '0};
                        end
                    end
                end
                S_SCALE: begin
                    r_quo   <= alu_res[DVD_W-1:0];
                    r_rem   <= '0;
                    r_sum   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // A non-negative trial result means the divisor fits.
                    if (!alu_res[ALU_W-1]) begin
                        r_rem <= alu_res[DIV_W-1:0];
                    end else begin
                        r_rem <= {r_rem[DIV_W-2:0], r_quo[DVD_W-1]};
                    end
                    r_quo <= {r_quo[DVD_W-2:0], !alu_res[ALU_W-1]};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(DVD_W - 1)) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_acc   <= alu_res;
                    r_state <= S_AVG;
                end
                S_AVG: begin
                    r_acc   <= alu_res;
                    r_state <= S_SEL;
                end
                S_SEL: begin
                    r_cnt  <= '0;
                    priority if (r_hot) begin
                        r_act   <= ACT_DEC;
                        r_prod  <= ALU_W'(BUMP_UNITY);
                        r_state <= S_DONE;
                    end else if (r_acc <= -ALU_W'(128)) begin
                        r_act   <= ACT_DEC;
                        r_prod  <= '0;
                        r_state <= S_NEG;
                    end else if (r_acc >= ALU_W'(128)) begin
                        r_act   <= ACT_INC;
                        r_prod  <= '0;
                        r_state <= S_MUL;
                    end else begin
                        r_act   <= ACT_HOLD;
                        r_prod  <= ALU_W'(BUMP_UNITY);
                        r_state <= S_DONE;
                    end
                end
                S_NEG: begin
                    r_acc   <= alu_res;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (wlen[r_cnt[2:0]]) begin
                        r_prod <= alu_res;
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(WLEN_W - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_data  <= '{power_action: r_act,
                                         bump_valid:   1'b1,
                                         bump_q8:      bump_final};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTHESIS
    // A report inside a window yields a hold result with no bump next cycle.
    a_inner_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !window_end) |=>
            (o_out_valid && !o_out_data.bump_valid
             && o_out_data.power_action == ACT_HOLD))
        else $error("inner report did not give a plain hold result");

    // A report that closes a window starts the sequencer and restarts the window.
    a_window_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && window_end) |=> (r_state == S_SCALE && r_pos == '0))
        else $error("window end did not start the sequencer");

    // The divider remainder always stays below the divisor.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < divisor))
        else $error("divider remainder out of range");

    // A window-end hold always carries a unity bump.
    a_hold_unity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.bump_valid
         && o_out_data.power_action == ACT_HOLD) |-> (o_out_data.bump_q8 == BUMP_UNITY))
        else $error("hold result without unity bump");
`endif

endmodule
